// File: rtl/u8fcd_pkg.sv
// shared types, constants and checks for the utf-8 first code point decoder
package u8fcd_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CP_W   = 21;
    localparam int unsigned LEFT_W = 2;
    localparam int unsigned LEN_W  = 3;

    localparam logic [CP_W-1:0] CP_MAX       = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO      = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI      = 21'h00DFFF;
    localparam logic [CP_W-1:0] MIN_LEN2     = 21'h000080;
    localparam logic [CP_W-1:0] MIN_LEN3     = 21'h000800;
    localparam logic [CP_W-1:0] MIN_LEN4     = 21'h010000;

    localparam logic [LEN_W-1:0] SEQ_LEN2 = 3'd2;
    localparam logic [LEN_W-1:0] SEQ_LEN3 = 3'd3;
    localparam logic [LEN_W-1:0] SEQ_LEN4 = 3'd4;

    // decoder phase, one-hot
    typedef enum logic [2:0] {
        PH_LEAD    = 3'b001,
        PH_COLLECT = 3'b010,
        PH_SKIP    = 3'b100
    } phase_t;

    // legal scalar value: nonzero, in range and not a surrogate
    function automatic logic scalar_ok(input logic [CP_W-1:0] cp);
        scalar_ok = (cp != '0) && (cp <= CP_MAX) && !((cp >= SURR_LO) && (cp <= SURR_HI));
    endfunction

    // smallest value that is not overlong for a sequence length
    function automatic logic [CP_W-1:0] min_for_len(input logic [LEN_W-1:0] len);
        case (len)
            SEQ_LEN2: min_for_len = MIN_LEN2;
            SEQ_LEN3: min_for_len = MIN_LEN3;
            SEQ_LEN4: min_for_len = MIN_LEN4;
            default:  min_for_len = '0;
        endcase
    endfunction

endpackage

// File: rtl/utf8_first_codepoint_decoder_top.sv
// top level of the utf-8 first code point decoder
//
// Input channel (in_valid/in_ready) carries one byte of a string per request,
// with last_byte set on the final byte of each string. Output channel
// (out_valid/out_ready) carries one request per string: codepoint and
// valid_res, where codepoint is zero whenever valid_res is low.
// The first utf-8 sequence of each string is decoded strictly: bad lead or
// continuation bytes, overlong forms, surrogates, zero and values above
// 0x10FFFF give an invalid result, as does a string that ends early.
// The result leaves at the byte that settles it; later bytes of that string
// are dropped until the last-byte mark.
// A byte is accepted into the input register and decoded from there; its
// result, if any, is written to the output register when the held byte moves
// on. Throughput: one byte per cycle while the receiver does not stall, set by
// the single decode step between the input register and the output register.
// Reset clears both register valids and returns the decoder to expecting a
// lead byte. When the receiver stalls with a result waiting, the held byte
// stays in the input register and in_ready drops; one byte is still taken
// while the output register is full.
module utf8_first_codepoint_decoder_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [u8fcd_pkg::BYTE_W-1:0]  in_byte,
    input  logic                          last_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [u8fcd_pkg::CP_W-1:0]    codepoint,
    output logic                          valid_res
);
    import u8fcd_pkg::*;

    logic                s1_valid_reg;
    logic [BYTE_W-1:0]   s1_byte_reg;
    logic                s1_last_reg;

    phase_t              phase_reg, phase_next;
    logic [LEFT_W-1:0]   left_reg, left_next;
    logic [LEN_W-1:0]    seq_len_reg, seq_len_next;
    logic [CP_W-1:0]     partial_reg, partial_next;

    logic                out_valid_reg;
    logic [CP_W-1:0]     cp_reg, cp_next;
    logic                ok_reg, ok_next;

    logic                step;
    logic                emit;
    phase_t              after;
    logic [CP_W-1:0]     acc;

    // the held byte moves on whenever the output register can take a result
    assign step     = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || step;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_byte_reg <= in_byte;
            s1_last_reg <= last_byte;
        end
    end

    // decode step for the held byte
    always_comb
    begin
        after        = s1_last_reg ? PH_LEAD : PH_SKIP;
        acc          = {partial_reg[CP_W-7:0], s1_byte_reg[5:0]};
        phase_next   = phase_reg;
        left_next    = left_reg;
        seq_len_next = seq_len_reg;
        partial_next = partial_reg;
        emit         = 1'b0;
        cp_next      = '0;
        ok_next      = 1'b0;
        case (phase_reg)
            PH_SKIP:
            begin
                if (s1_last_reg)
                begin
                    phase_next = PH_LEAD;
                end
            end
            PH_COLLECT:
            begin
                if (s1_byte_reg[7:6] != 2'b10)
                begin
                    emit       = 1'b1;
                    phase_next = after;
                end
                else if (left_reg <= 2'd1)
                begin
                    emit         = 1'b1;
                    ok_next      = (acc >= min_for_len(seq_len_reg)) && scalar_ok(acc);
                    cp_next      = ok_next ? acc : '0;
                    partial_next = acc;
                    left_next    = '0;
                    phase_next   = after;
                end
                else
                begin
                    partial_next = acc;
                    left_next    = left_reg - 2'd1;
                    if (s1_last_reg)
                    begin
                        emit       = 1'b1;
                        phase_next = PH_LEAD;
                    end
                end
            end
            default:
            begin
                // lead byte; an unused phase code acts the same
                if (!s1_byte_reg[7])
                begin
                    emit       = 1'b1;
                    ok_next    = (s1_byte_reg != '0);
                    cp_next    = {{(CP_W-BYTE_W){1'b0}}, s1_byte_reg};
                    phase_next = after;
                end
                else if ((s1_byte_reg[7:5] != 3'b110) && (s1_byte_reg[7:4] != 4'b1110)
                         && (s1_byte_reg[7:3] != 5'b11110))
                begin
                    emit       = 1'b1;
                    phase_next = after;
                end
                else if (s1_last_reg)
                begin
                    emit       = 1'b1;
                    phase_next = PH_LEAD;
                end
                else
                begin
                    phase_next = PH_COLLECT;
                    if (s1_byte_reg[7:5] == 3'b110)
                    begin
                        seq_len_next = SEQ_LEN2;
                        left_next    = 2'd1;
                        partial_next = {{(CP_W-5){1'b0}}, s1_byte_reg[4:0]};
                    end
                    else if (s1_byte_reg[7:4] == 4'b1110)
                    begin
                        seq_len_next = SEQ_LEN3;
                        left_next    = 2'd2;
                        partial_next = {{(CP_W-4){1'b0}}, s1_byte_reg[3:0]};
                    end
                    else
                    begin
                        seq_len_next = SEQ_LEN4;
                        left_next    = 2'd3;
                        partial_next = {{(CP_W-3){1'b0}}, s1_byte_reg[2:0]};
                    end
                end
            end
        endcase
    end

    // decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_LEAD;
            left_reg    <= '0;
            seq_len_reg <= '0;
            partial_reg <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            left_reg    <= left_next;
            seq_len_reg <= seq_len_next;
            partial_reg <= partial_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= emit;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && emit)
        begin
            cp_reg <= cp_next;
            ok_reg <= ok_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign codepoint = cp_reg;
    assign valid_res = ok_reg;

`ifndef ASSERT_OFF
    // an invalid result always carries a zero code point
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !valid_res) |-> (codepoint == '0))
        else $error("invalid result with nonzero code point");

    // a valid result is a legal scalar value
    a_valid_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && valid_res) |-> scalar_ok(codepoint))
        else $error("valid result outside the legal range");

    // collecting always expects at least one more continuation byte
    a_collect_left: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_COLLECT) |-> (left_reg != '0))
        else $error("collecting with no bytes left");

    // input is blocked only by a held byte that cannot move
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && out_valid_reg && !out_ready))
        else $error("input stalled without cause");
`endif

endmodule

// File: test/utf8_first_codepoint_decoder_top_tb.sv
// self-checking testbench for the utf-8 first code point decoder with random stalls
module utf8_first_codepoint_decoder_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import u8fcd_pkg::*;

    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned PHASE_BYTES  = 110;
    localparam int unsigned DRAIN_CYCLES = 4;

    // one decoded result as it leaves the block
    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            ok;
    } cp_result_t;

    // decoder state mirror and queue of expected code points
    class codepoint_scoreboard;
        phase_t            state;
        logic [LEFT_W-1:0] left;
        logic [LEN_W-1:0]  seq_len;
        logic [CP_W-1:0]   acc;
        cp_result_t        expected_codepoints[$];
        int unsigned       errors;
        int unsigned       good_seen;
        int unsigned       bad_seen;

        function new();
            state     = PH_LEAD;
            left      = '0;
            seq_len   = '0;
            acc       = '0;
            errors    = 0;
            good_seen = 0;
            bad_seen  = 0;
        endfunction

        function int unsigned pending();
            return expected_codepoints.size();
        endfunction

        // nonzero, at most the top scalar, and outside the surrogate block
        function logic is_scalar(logic [CP_W-1:0] v);
            return (v != '0) && (v <= CP_MAX) && !((v >= SURR_LO) && (v <= SURR_HI));
        endfunction

        function void push_result(logic [CP_W-1:0] v, logic ok);
            cp_result_t r;
            r.cp = ok ? v : '0;
            r.ok = ok;
            expected_codepoints.push_back(r);
        endfunction

        // advance the mirror by one accepted byte request
        function void note_byte(logic [BYTE_W-1:0] b, logic last);
            phase_t            after_res;
            logic [CP_W-1:0]   floor_val;
            logic [CP_W-1:0]   init;
            logic [LEN_W-1:0]  len_n;
            after_res = last ? PH_LEAD : PH_SKIP;
            case (state)
                PH_SKIP:
                begin
                    if (last)
                        state = PH_LEAD;
                end
                PH_COLLECT:
                begin
                    if (b[7:6] != 2'b10)
                    begin
                        state = after_res;
                        push_result('0, 1'b0);
                    end
                    else
                    begin
                        acc = {acc[CP_W-7:0], b[5:0]};
                        if (left <= 2'd1)
                        begin
                            case (seq_len)
                                SEQ_LEN2: floor_val = MIN_LEN2;
                                SEQ_LEN3: floor_val = MIN_LEN3;
                                SEQ_LEN4: floor_val = MIN_LEN4;
                                default:  floor_val = '0;
                            endcase
                            left  = '0;
                            state = after_res;
                            push_result(acc, (acc >= floor_val) && is_scalar(acc));
                        end
                        else
                        begin
                            left = left - 2'd1;
                            if (last)
                            begin
                                state = PH_LEAD;
                                push_result('0, 1'b0);
                            end
                        end
                    end
                end
                // expecting a lead byte, also any stray encoding
                default:
                begin
                    if (!b[7])
                    begin
                        state = after_res;
                        push_result({13'd0, b}, is_scalar({13'd0, b}));
                    end
                    else
                    begin
                        init = '0;
                        if (b[7:5] == 3'b110)
                        begin
                            len_n = SEQ_LEN2;
                            init  = {16'd0, b[4:0]};
                        end
                        else if (b[7:4] == 4'b1110)
                        begin
                            len_n = SEQ_LEN3;
                            init  = {17'd0, b[3:0]};
                        end
                        else if (b[7:3] == 5'b11110)
                        begin
                            len_n = SEQ_LEN4;
                            init  = {18'd0, b[2:0]};
                        end
                        else
                            len_n = '0;
                        if (len_n == '0)
                        begin
                            state = after_res;
                            push_result('0, 1'b0);
                        end
                        else if (last)
                        begin
                            state = PH_LEAD;
                            push_result('0, 1'b0);
                        end
                        else
                        begin
                            acc     = init;
                            seq_len = len_n;
                            left    = len_n[LEFT_W-1:0] - 2'd1;
                            state   = PH_COLLECT;
                        end
                    end
                end
            endcase
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        // compare a returned result with the oldest expectation
        task check_codepoint(logic [CP_W-1:0] cp, logic ok);
            cp_result_t exp_r;
            if (expected_codepoints.size() == 0)
                report_mismatch($sformatf("unexpected result cp=%h valid_res=%b", cp, ok));
            else
            begin
                exp_r = expected_codepoints.pop_front();
                if (cp !== exp_r.cp)
                    report_mismatch($sformatf("codepoint %h, expected %h", cp, exp_r.cp));
                if (ok !== exp_r.ok)
                    report_mismatch($sformatf("valid_res %b, expected %b", ok, exp_r.ok));
                if (exp_r.ok)
                    good_seen++;
                else
                    bad_seen++;
            end
        endtask

        task check_drained();
            if (expected_codepoints.size() != 0)
                report_mismatch($sformatf("%0d results never returned",
                                          expected_codepoints.size()));
        endtask
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [BYTE_W-1:0]   in_byte = '0;
    logic                last_byte = 1'b0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [CP_W-1:0]     codepoint;
    logic                valid_res;

    codepoint_scoreboard sb = new();
    logic [BYTE_W-1:0]   str_bytes[$];
    int unsigned         idle_pct  = 0;
    int unsigned         stall_pct = 0;
    int unsigned         bytes_sent = 0;
    int unsigned         strings_sent = 0;

    utf8_first_codepoint_decoder_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .last_byte (last_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .codepoint (codepoint),
        .valid_res (valid_res)
    );

    // clock
    initial
    begin
        forever #2 clk = ~clk;
    end

    // one byte request, held until the handshake completes
    task send_byte(logic [BYTE_W-1:0] b, logic last);
        logic taken;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_byte   <= b;
        last_byte <= last;
        do
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        while (!taken);
        sb.note_byte(b, last);
        bytes_sent++;
    endtask

    // send the staged string with the mark on its final byte
    task send_string();
        for (int i = 0; i < str_bytes.size(); i++)
            send_byte(str_bytes[i], i == str_bytes.size() - 1);
        strings_sent++;
    endtask

    // stop sending until every expected result is back
    task wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // append an encoding of v with the given length, overlong forms allowed
    function void encode_seq(int unsigned n, logic [CP_W-1:0] v);
        case (n)
            1: str_bytes.push_back({1'b0, v[6:0]});
            2:
            begin
                str_bytes.push_back({3'b110, v[10:6]});
                str_bytes.push_back({2'b10, v[5:0]});
            end
            3:
            begin
                str_bytes.push_back({4'b1110, v[15:12]});
                str_bytes.push_back({2'b10, v[11:6]});
                str_bytes.push_back({2'b10, v[5:0]});
            end
            default:
            begin
                str_bytes.push_back({5'b11110, v[20:18]});
                str_bytes.push_back({2'b10, v[17:12]});
                str_bytes.push_back({2'b10, v[11:6]});
                str_bytes.push_back({2'b10, v[5:0]});
            end
        endcase
    endfunction

    // value for a sequence, biased toward boundaries and illegal ranges
    function logic [CP_W-1:0] pick_value(int unsigned n);
        logic [CP_W-1:0] mask;
        logic [CP_W-1:0] v;
        mask = (n == 1) ? 21'h7F : (n == 2) ? 21'h7FF : (n == 3) ? 21'hFFFF : 21'h1FFFFF;
        v = 21'($urandom()) & mask;
        case ($urandom_range(0, 9))
            5: v = (n == 1) ? 21'($urandom_range(0, 1)) :
                   (n == 2) ? MIN_LEN2 - 21'($urandom_range(0, 1)) :
                   (n == 3) ? MIN_LEN3 - 21'($urandom_range(0, 1)) :
                              MIN_LEN4 - 21'($urandom_range(0, 1));
            6: v = mask;
            7: if (n == 3) v = SURR_LO + 21'($urandom_range(0, 'h7FF));
            8: if (n == 4) v = CP_MAX + 21'($urandom_range(0, 1));
            default: ;
        endcase
        return v;
    endfunction

    // random string: mostly well formed, some cut short, corrupted or noise
    function void build_random_string();
        int unsigned n;
        int unsigned k;
        int unsigned pos;
        str_bytes.delete();
        k = $urandom_range(0, 9);
        n = $urandom_range(1, 4);
        if (k >= 6 && k <= 8)
            n = $urandom_range(2, 4);
        if (k == 9)
        begin
            repeat ($urandom_range(1, 4))
                str_bytes.push_back(BYTE_W'($urandom()));
            return;
        end
        encode_seq(n, pick_value(n));
        if (k == 6 || k == 7)
        begin
            repeat ($urandom_range(1, n - 1))
                void'(str_bytes.pop_back());
            return;
        end
        if (k == 8)
        begin
            pos = $urandom_range(1, n - 1);
            str_bytes[pos] = BYTE_W'($urandom());
            if (str_bytes[pos][7:6] == 2'b10)
                str_bytes[pos][6] = 1'b1;
        end
        repeat ($urandom_range(0, 3))
            str_bytes.push_back(BYTE_W'($urandom()));
    endfunction

    // receiver: sample between edges, check at the accepting edge
    initial
    begin
        logic            take;
        logic [CP_W-1:0] got_cp;
        logic            got_ok;
        forever
        begin
            @(negedge clk);
            take   = out_valid && out_ready;
            got_cp = codepoint;
            got_ok = valid_res;
            @(posedge clk);
            if (take)
                sb.check_codepoint(got_cp, got_ok);
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // watchdog on cycles with no handshake on either side
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(negedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout after %0d cycles without a handshake", STALL_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // stimulus
    initial
    begin
        int unsigned phase_start;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed strings covering the special cases
        str_bytes = '{8'h00};                       send_string();  // zero lead
        str_bytes = '{8'h7F, 8'h41};                send_string();  // top ascii, trailing byte
        str_bytes = '{8'h80};                       send_string();  // stray continuation as lead
        str_bytes = '{8'hFF};                       send_string();  // illegal lead
        str_bytes = '{8'hC2};                       send_string();  // lead is also last
        str_bytes = '{8'hC2, 8'h41};                send_string();  // bad continuation
        str_bytes = '{8'hE2, 8'h82};                send_string();  // string ends early
        str_bytes = '{8'hC1, 8'hBF};                send_string();  // overlong two byte
        str_bytes = '{8'hED, 8'hA0, 8'h80};         send_string();  // surrogate
        str_bytes = '{8'hF4, 8'h8F, 8'hBF, 8'hBF};  send_string();  // top scalar
        str_bytes = '{8'hF4, 8'h90, 8'h80, 8'h80};  send_string();  // beyond top scalar
        wait_drained();

        // random phases with different idle and stall mixes
        for (int p = 0; p < 4; p++)
        begin
            idle_pct  = (p == 1) ? 69 : (p == 3) ? 37 : 0;
            stall_pct = (p == 2) ? 69 : (p == 3) ? 37 : 0;
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
            begin
                build_random_string();
                send_string();
            end
            wait_drained();
        end

        in_valid <= 1'b0;
        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.check_drained();
        $display("sent %0d strings in %0d bytes under four idle and stall mixes",
                 strings_sent, bytes_sent);
        $display("checked %0d legal and %0d rejected code points, %0d mismatches",
                 sb.good_seen, sb.bad_seen, sb.errors);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/u8fcd_pkg.sv
rtl/utf8_first_codepoint_decoder_top.sv
test/utf8_first_codepoint_decoder_top_tb.sv
